### hw/rtl/mipbt_pkg.sv
// shared types and constants for the mobile ip binding table
// no dependencies; every other file of the block imports this package
`default_nettype none

package mipbt_pkg;

    localparam int NUM_BINDINGS = 16;
    localparam int IDX_W        = (NUM_BINDINGS > 1) ? $clog2(NUM_BINDINGS) : 1;

    localparam int ADDR_W  = 32;
    localparam int LIFE_W  = 16;
    localparam int ID_W    = 16;
    localparam int FLAGS_W = 8;
    localparam int CODE_W  = 2;
    localparam int EVENT_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [ADDR_W-1:0]  HOME_NET_MASK      = 32'hFFFF_FF00;
    localparam logic [FLAGS_W-1:0] FLAG_RESERVED_MASK = 8'h03;
    localparam int                 FLAG_SIMUL_BIT     = 7;
    localparam logic [LIFE_W-1:0]  MAX_LIFETIME_RESET = 16'd1800;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIFETIME  = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        CODE_ACCEPT   = 2'd0,
        CODE_SIMUL    = 2'd1,
        CODE_RESERVED = 2'd2
    } reply_code_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_NEW   = 3'd1,
        EV_REREG = 3'd2,
        EV_DEREG = 3'd3,
        EV_FULL  = 3'd4
    } binding_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_TICK
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic start;      // input beat taken, capture fields and reset the walk
        logic scan_req;   // look at one table entry for a request
        logic scan_tick;  // count one table entry down
        logic commit;     // update the table and load the reply register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;       // walk index is on the final entry
        logic out_hold;   // reply register full and not taken this cycle
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/mipbt_if.sv
// valid/ready channel interfaces for requests and replies
// depends on mipbt_pkg for field widths
`default_nettype none

interface mipbt_req_if;
    import mipbt_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic                checksum_ok;
    logic [ADDR_W-1:0]   source_address;
    logic [FLAGS_W-1:0]  request_flags;
    logic [LIFE_W-1:0]   requested_lifetime;
    logic [ADDR_W-1:0]   home_address;
    logic [ADDR_W-1:0]   home_agent_address;
    logic [ADDR_W-1:0]   care_of_address;
    logic [ID_W-1:0]     request_id;

    modport source (
        output valid, op, checksum_ok, source_address, request_flags,
               requested_lifetime, home_address, home_agent_address,
               care_of_address, request_id,
        input  ready
    );

    modport sink (
        input  valid, op, checksum_ok, source_address, request_flags,
               requested_lifetime, home_address, home_agent_address,
               care_of_address, request_id,
        output ready
    );
endinterface

interface mipbt_rsp_if;
    import mipbt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   reply_code;
    logic [LIFE_W-1:0]   granted_lifetime;
    logic [ADDR_W-1:0]   reply_home_address;
    logic [ADDR_W-1:0]   reply_home_agent;
    logic [ID_W-1:0]     reply_id;
    logic [EVENT_W-1:0]  binding_event;

    modport source (
        output valid, reply_code, granted_lifetime, reply_home_address,
               reply_home_agent, reply_id, binding_event,
        input  ready
    );

    modport sink (
        input  valid, reply_code, granted_lifetime, reply_home_address,
               reply_home_agent, reply_id, binding_event,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/mipbt_ctrl.sv
// controller state machine: sequences the table walk for requests and ticks
// depends on mipbt_pkg
`default_nettype none

module mipbt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_op,
    input  wire logic                   in_checksum_ok,
    output logic                        in_ready,
    input  wire mipbt_pkg::dp_status_t  status,
    output mipbt_pkg::dp_cmd_t          cmd
);
    import mipbt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (in_op == OP_TICK)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (in_checksum_ok)
                    begin
                        state_next = ST_SCAN;
                    end
                    // bad checksum: beat dropped, stay idle
                end
            end
            ST_SCAN:
            begin
                cmd.scan_req = 1'b1;
                if (status.last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_hold)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                cmd.scan_tick = 1'b1;
                if (status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mipbt_dpath.sv
// datapath: config registers, binding table, walk index, reply register
// depends on mipbt_pkg; driven by mipbt_ctrl through dp_cmd_t
`default_nettype none

module mipbt_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mipbt_pkg::dp_cmd_t                cmd,
    output mipbt_pkg::dp_status_t                  status,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mipbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mipbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [mipbt_pkg::ADDR_W-1:0]      source_address,
    input  wire logic [mipbt_pkg::FLAGS_W-1:0]     request_flags,
    input  wire logic [mipbt_pkg::LIFE_W-1:0]      requested_lifetime,
    input  wire logic [mipbt_pkg::ADDR_W-1:0]      home_address,
    input  wire logic [mipbt_pkg::ADDR_W-1:0]      home_agent_address,
    input  wire logic [mipbt_pkg::ADDR_W-1:0]      care_of_address,
    input  wire logic [mipbt_pkg::ID_W-1:0]        request_id,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_ready,
    output logic [mipbt_pkg::CODE_W-1:0]           reply_code,
    output logic [mipbt_pkg::LIFE_W-1:0]           granted_lifetime,
    output logic [mipbt_pkg::ADDR_W-1:0]           reply_home_address,
    output logic [mipbt_pkg::ADDR_W-1:0]           reply_home_agent,
    output logic [mipbt_pkg::ID_W-1:0]             reply_id,
    output logic [mipbt_pkg::EVENT_W-1:0]          binding_event
);
    import mipbt_pkg::*;

    // configuration
    logic [ADDR_W-1:0] agent_address_reg;
    logic [LIFE_W-1:0] max_lifetime_reg;

    // captured request
    reply_code_t       code_reg;
    logic [LIFE_W-1:0] granted_reg;
    logic              at_home_reg;
    logic [ADDR_W-1:0] home_reg;
    logic [ADDR_W-1:0] agent_sel_reg;
    logic [ADDR_W-1:0] coa_reg;
    logic [ID_W-1:0]   id_reg;

    // walk state
    logic [IDX_W-1:0]  idx_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // binding table
    logic              valid_reg [NUM_BINDINGS];
    logic [ADDR_W-1:0] tab_home   [NUM_BINDINGS];
    logic [ADDR_W-1:0] tab_coa    [NUM_BINDINGS];
    logic [LIFE_W-1:0] tab_remain [NUM_BINDINGS];
    logic [ID_W-1:0]   tab_id     [NUM_BINDINGS];

    // reply register
    logic              rsp_valid_reg;
    reply_code_t       out_code_reg;
    logic [LIFE_W-1:0] out_granted_reg;
    logic [ADDR_W-1:0] out_home_reg;
    logic [ADDR_W-1:0] out_agent_reg;
    logic [ID_W-1:0]   out_id_reg;
    binding_event_t    out_event_reg;

    reply_code_t       code_next;
    logic [LIFE_W-1:0] granted_next;
    logic              at_home_next;
    logic              cur_valid;
    logic              hit;
    logic              cand;
    logic [LIFE_W-1:0] remain_dec;
    logic              store;
    binding_event_t    event_next;

    // request decode at capture
    always_comb
    begin
        if ((request_flags & FLAG_RESERVED_MASK) != '0)
        begin
            code_next = CODE_RESERVED;
        end
        else if (request_flags[FLAG_SIMUL_BIT])
        begin
            code_next = CODE_SIMUL;
        end
        else
        begin
            code_next = CODE_ACCEPT;
        end
        granted_next = (requested_lifetime > max_lifetime_reg) ? max_lifetime_reg
                                                               : requested_lifetime;
        at_home_next = ((source_address ^ agent_address_reg) & HOME_NET_MASK) == '0;
    end

    // per-entry walk logic
    always_comb
    begin
        cur_valid  = valid_reg[idx_reg];
        hit        = cur_valid && (tab_home[idx_reg] == home_reg) && !match_found_reg;
        // removed binding frees its slot for the store that follows
        cand       = !cur_valid || hit;
        remain_dec = tab_remain[idx_reg] - LIFE_W'(1);
    end

    // outcome of a request after the walk
    always_comb
    begin
        store      = 1'b0;
        event_next = EV_NONE;
        if (code_reg == CODE_ACCEPT)
        begin
            if (at_home_reg || (granted_reg == '0))
            begin
                event_next = EV_DEREG;
            end
            else if (!free_found_reg)
            begin
                event_next = EV_FULL;
            end
            else
            begin
                store      = 1'b1;
                event_next = match_found_reg ? EV_REREG : EV_NEW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agent_address_reg <= '0;
            max_lifetime_reg  <= MAX_LIFETIME_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_AGENT_ADDRESS: agent_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_MAX_LIFETIME:  max_lifetime_reg  <= cfg_data[LIFE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            code_reg      <= code_next;
            granted_reg   <= granted_next;
            at_home_reg   <= at_home_next;
            home_reg      <= home_address;
            agent_sel_reg <= at_home_next ? agent_address_reg : home_agent_address;
            coa_reg       <= care_of_address;
            id_reg        <= request_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end
        else if (cmd.start)
        begin
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (cmd.scan_req || cmd.scan_tick)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.scan_req)
            begin
                if (hit)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= idx_reg;
                end
                if (cand && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BINDINGS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cmd.scan_tick && cur_valid && (remain_dec == '0))
            begin
                valid_reg[idx_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                // a store into the removed slot keeps it valid
                if (match_found_reg && !(store && (match_idx_reg == free_idx_reg)))
                begin
                    valid_reg[match_idx_reg] <= 1'b0;
                end
                if (store)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_tick && cur_valid)
        begin
            tab_remain[idx_reg] <= remain_dec;
        end
        if (cmd.commit && store)
        begin
            tab_home[free_idx_reg]   <= home_reg;
            tab_coa[free_idx_reg]    <= coa_reg;
            tab_remain[free_idx_reg] <= granted_reg;
            tab_id[free_idx_reg]     <= id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_code_reg    <= code_reg;
            out_granted_reg <= granted_reg;
            out_home_reg    <= home_reg;
            out_agent_reg   <= agent_sel_reg;
            out_id_reg      <= id_reg;
            out_event_reg   <= event_next;
        end
    end

    assign status.last     = (idx_reg == IDX_W'(NUM_BINDINGS - 1));
    assign status.out_hold = rsp_valid_reg && !rsp_ready;

    assign rsp_valid          = rsp_valid_reg;
    assign reply_code         = out_code_reg;
    assign granted_lifetime   = out_granted_reg;
    assign reply_home_address = out_home_reg;
    assign reply_home_agent   = out_agent_reg;
    assign reply_id           = out_id_reg;
    assign binding_event      = out_event_reg;

endmodule

`default_nettype wire

### hw/rtl/mobile_ip_binding_table.sv
// top level of the home-agent registration engine
// depends on mipbt_pkg, mipbt_req_if, mipbt_rsp_if, mipbt_ctrl, mipbt_dpath
`default_nettype none

// Home-agent registration engine with a NUM_BINDINGS-entry binding table.
// Each beat on req is a registration request or a one-second tick. A request
// walks the table one entry per clock to find an existing binding and the
// lowest free slot, then updates the table and loads the reply register in
// its commit step. A tick walks the table the same way, decrementing each
// binding and expiring it at zero, and gives no reply. A request with a failed
// checksum is dropped in its accept cycle. The reply register holds one
// finished reply, so the next beat is accepted while it waits on rsp; the
// commit step stalls only if a second reply is ready before the first is
// taken. Configuration writes through cfg_wr_en/cfg_index/cfg_data must be
// made while the block is idle. Reset clears all bindings; no clearing pass
// is needed.
module mobile_ip_binding_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mipbt_req_if.sink                              req,
    mipbt_rsp_if.source                            rsp,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mipbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [mipbt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mipbt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    assign req.ready = in_ready;

    mipbt_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (req.valid),
        .in_op          (req.op),
        .in_checksum_ok (req.checksum_ok),
        .in_ready       (in_ready),
        .status         (status),
        .cmd            (cmd)
    );

    mipbt_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .source_address     (req.source_address),
        .request_flags      (req.request_flags),
        .requested_lifetime (req.requested_lifetime),
        .home_address       (req.home_address),
        .home_agent_address (req.home_agent_address),
        .care_of_address    (req.care_of_address),
        .request_id         (req.request_id),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .reply_code         (rsp.reply_code),
        .granted_lifetime   (rsp.granted_lifetime),
        .reply_home_address (rsp.reply_home_address),
        .reply_home_agent   (rsp.reply_home_agent),
        .reply_id           (rsp.reply_id),
        .binding_event      (rsp.binding_event)
    );

endmodule

`default_nettype wire

### hw/rtl/mipbt_checker.sv
// port-level checks for mobile_ip_binding_table, attached by bind
// depends on mipbt_pkg and the top level's ports
`default_nettype none

module mipbt_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    input  wire logic                             req_ready,
    input  wire logic                             rsp_valid,
    input  wire logic                             rsp_ready,
    input  wire logic [mipbt_pkg::CODE_W-1:0]     reply_code,
    input  wire logic [mipbt_pkg::LIFE_W-1:0]     granted_lifetime,
    input  wire logic [mipbt_pkg::EVENT_W-1:0]    binding_event
);
    import mipbt_pkg::*;

    // a stalled reply beat stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(reply_code)
            && $stable(binding_event) && $stable(granted_lifetime))
        else $error("reply beat changed while stalled");

    // rejected requests never touch a binding outcome
    a_reject_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (reply_code != CODE_ACCEPT) |-> binding_event == EV_NONE)
        else $error("rejected request reports a binding event");

    // a stored binding always has a nonzero lifetime
    a_store_lifetime: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((binding_event == EV_NEW) || (binding_event == EV_REREG))
            |-> granted_lifetime != '0)
        else $error("binding stored with zero lifetime");

    // a reply needs the table walk after its request beat, so none rises straight after an accepted beat
    a_no_early_reply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("reply appeared right after a request beat");

endmodule

bind mobile_ip_binding_table mipbt_checker u_mipbt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .reply_code       (rsp.reply_code),
    .granted_lifetime (rsp.granted_lifetime),
    .binding_event    (rsp.binding_event)
);

`default_nettype wire
